@@ hw/rtl/tsac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tsac_pkg;

  localparam int unsigned SETS_DEF  = 64;
  localparam int unsigned WORDS_DEF = 4;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;

  localparam logic [1:0] KIND_RD_DATA = 2'd0;
  localparam logic [1:0] KIND_MEM_REQ = 2'd1;
  localparam logic [1:0] KIND_MEM_WR  = 2'd2;
  localparam logic [1:0] KIND_WR_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [31:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] mem_address;
    logic [31:0] data_out;
    logic        was_hit;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    D_NONE    = 3'd0,
    D_RD_CPU  = 3'd1,
    D_RD_WB   = 3'd2,
    D_WR_CPU  = 3'd3,
    D_WR_FILL = 3'd4
  } dop_e;

  typedef enum logic [2:0] {
    E_RD   = 3'd0,
    E_REQ  = 3'd1,
    E_WB   = 3'd2,
    E_WT   = 3'd3,
    E_DONE = 3'd4
  } esrc_e;

  typedef struct packed {
    logic  clr;
    logic  div_start;
    logic  take_cpu;
    logic  take_fill;
    logic  meta_rd;
    logic  lookup;
    logic  miss;
    logic  commit;
    dop_e  dop;
    logic  emit;
    esrc_e esrc;
    logic  cnt_inc;
    logic  cnt_clr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic hit;
    logic vdirty;
    logic cpu_wr;
    logic wt;
    logic cnt_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/tsac_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsac_div #(
  parameter int unsigned DIVISOR = 4,
  parameter int unsigned RW      = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [31:0]   dividend_i,
  output logic               done_o,
  output logic [31:0]        quot_o,
  output logic [RW-1:0]      rem_o
);

  // quotient by reciprocal multiplication, exact for any 32-bit dividend
  localparam int unsigned    SH     = 32 + $clog2(DIVISOR);
  localparam logic [64:0]    MUL_W  = ((65'd1 << SH) + 65'(DIVISOR - 1)) / 65'(DIVISOR);
  localparam logic [32:0]    MUL    = MUL_W[32:0];
  localparam logic [RW-1:0]  DIV_LO = RW'(DIVISOR);

  logic          done_q;
  logic [RW-1:0] xlo_q;
  logic [64:0]   prod_q;
  logic [31:0]   quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xlo_q  <= dividend_i[RW-1:0];
      prod_q <= dividend_i * MUL;
    end
  end

  assign quot   = 32'(prod_q >> SH);
  assign done_o = done_q;
  assign quot_o = quot;
  assign rem_o  = xlo_q - RW'(quot[RW-1:0] * DIV_LO);

endmodule

`default_nettype wire

@@ hw/rtl/tsac_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsac_dp
  import tsac_pkg::*;
#(
  parameter int unsigned SETS  = SETS_DEF,
  parameter int unsigned WORDS = WORDS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i,
  input  wire in_item_t  in_item_i,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output out_item_t      out_item_o,
  input  wire cmd_t      cmd_i,
  output status_t        status_o
);

  localparam int unsigned OFF_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned TAG_W = 33 - $clog2(WORDS * SETS + 1);
  localparam int unsigned WAY_W = TAG_W + 2;
  localparam int unsigned ROW_W = 2 * WAY_W + 1;
  localparam int unsigned DA_W  = SET_W + 1 + OFF_W;
  localparam int unsigned LINE  = WORDS * SETS;

  // meta row: {lru, way1, way0}, way = {valid, dirty, tag}
  logic [ROW_W-1:0] meta_mem [SETS];
  logic [31:0]      data_mem [1 << DA_W];

  logic [ROW_W-1:0] meta_rd_q;
  logic [31:0]      rdata_q;

  logic             wt_q, out_valid_q;
  logic [SET_W-1:0] clr_q;
  logic [OFF_W-1:0] cnt_q;
  out_item_t        out_item_q;

  logic             cpu_wr_q, hit_q, way_q, vdirty_q;
  logic [31:0]      cpu_addr_q, cpu_data_q, fill_q, wb_base_q, rq_base_q;
  logic [OFF_W-1:0] off_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q, vtag_q;

  logic             d1_done, d2_done;
  logic [31:0]      q1, q2;
  logic [OFF_W-1:0] r1;
  logic [SET_W-1:0] r2;

  tsac_div #(.DIVISOR(WORDS), .RW(OFF_W)) u_div_off (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start), .dividend_i(cpu_addr_q),
    .done_o(d1_done), .quot_o(q1), .rem_o(r1)
  );

  tsac_div #(.DIVISOR(SETS), .RW(SET_W)) u_div_set (
    .clk_i, .rst_ni,
    .start_i(d1_done), .dividend_i(q1),
    .done_o(d2_done), .quot_o(q2), .rem_o(r2)
  );

  logic [WAY_W-1:0] w0, w1, sel_w, cur_w, upd_w;
  logic             lru, hit0, hit1, vic_way, dirty_new, cnt_last;
  logic [ROW_W-1:0] row_new;

  always_comb begin
    w0       = meta_rd_q[WAY_W-1:0];
    w1       = meta_rd_q[2*WAY_W-1:WAY_W];
    lru      = meta_rd_q[ROW_W-1];
    hit0     = w0[WAY_W-1] && (w0[TAG_W-1:0] == tag_q);
    hit1     = w1[WAY_W-1] && (w1[TAG_W-1:0] == tag_q);
    if (hit0)              vic_way = 1'b0;
    else if (hit1)         vic_way = 1'b1;
    else if (!w0[WAY_W-1]) vic_way = 1'b0;
    else if (!w1[WAY_W-1]) vic_way = 1'b1;
    else                   vic_way = lru;
    sel_w    = vic_way ? w1 : w0;
    cur_w    = way_q ? w1 : w0;
    dirty_new = (hit_q & cur_w[WAY_W-2]) | (cpu_wr_q & ~wt_q);
    if (cmd_i.commit) begin
      upd_w   = {1'b1, dirty_new, tag_q};
      row_new = way_q ? {~way_q, upd_w, w0} : {~way_q, w1, upd_w};
    end else begin
      upd_w   = {2'b00, cur_w[TAG_W-1:0]};
      row_new = way_q ? {lru, upd_w, w0} : {lru, w1, upd_w};
    end
    cnt_last = (cnt_q == OFF_W'(WORDS - 1));
  end

  // metadata store
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      meta_mem[clr_q] <= '0;
    end else if (cmd_i.miss || cmd_i.commit) begin
      meta_mem[set_q] <= row_new;
    end
    if (cmd_i.meta_rd) begin
      meta_rd_q <= meta_mem[set_q];
    end
  end

  // data store
  logic            dwe, dre;
  logic [DA_W-1:0] dwa, dra;
  logic [31:0]     dwd;

  always_comb begin
    dwe = 1'b0;
    dre = 1'b0;
    dwa = {set_q, way_q, off_q};
    dra = {set_q, way_q, off_q};
    dwd = cpu_data_q;
    unique case (cmd_i.dop)
      D_WR_CPU: dwe = 1'b1;
      D_WR_FILL: begin
        dwe = 1'b1;
        dwa = {set_q, way_q, cnt_q};
        dwd = fill_q;
      end
      D_RD_CPU: dre = 1'b1;
      D_RD_WB: begin
        dre = 1'b1;
        dra = {set_q, way_q, cnt_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      data_mem[dwa] <= dwd;
    end
    if (dre) begin
      rdata_q <= data_mem[dra];
    end
  end

  out_item_t item_d;

  always_comb begin
    item_d = '{kind: KIND_RD_DATA, mem_address: cpu_addr_q, data_out: rdata_q,
               was_hit: hit_q, last: 1'b1};
    case (cmd_i.esrc)
      E_REQ: item_d = '{kind: KIND_MEM_REQ, mem_address: rq_base_q + 32'(cnt_q),
                        data_out: '0, was_hit: 1'b0, last: cnt_last};
      E_WB:  item_d = '{kind: KIND_MEM_WR, mem_address: wb_base_q + 32'(cnt_q),
                        data_out: rdata_q, was_hit: 1'b0, last: 1'b0};
      E_WT:  item_d = '{kind: KIND_MEM_WR, mem_address: cpu_addr_q,
                        data_out: cpu_data_q, was_hit: hit_q, last: 1'b0};
      E_DONE: item_d = '{kind: KIND_WR_DONE, mem_address: cpu_addr_q,
                         data_out: cpu_data_q, was_hit: hit_q, last: 1'b1};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q        <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) wt_q <= cfg_wdata_i;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_item_q <= item_d;
    if (cmd_i.take_cpu) begin
      cpu_addr_q <= in_item_i.address;
      cpu_data_q <= in_item_i.data_word;
      cpu_wr_q   <= (in_item_i.action == ACT_WRITE);
    end
    if (cmd_i.take_fill) fill_q <= in_item_i.data_word;
    if (d1_done) off_q <= r1;
    if (d2_done) begin
      set_q <= r2;
      tag_q <= q2[TAG_W-1:0];
    end
    if (cmd_i.lookup) begin
      hit_q    <= hit0 | hit1;
      way_q    <= vic_way;
      vdirty_q <= sel_w[WAY_W-1] & sel_w[WAY_W-2];
      vtag_q   <= sel_w[TAG_W-1:0];
    end
    if (cmd_i.miss) begin
      wb_base_q <= 32'(vtag_q) * 32'(LINE) + 32'(set_q) * 32'(WORDS);
      rq_base_q <= cpu_addr_q - 32'(off_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign status_o = '{
    clr_last: (clr_q == SET_W'(SETS - 1)),
    div_done: d2_done,
    hit:      hit0 | hit1,
    vdirty:   vdirty_q,
    cpu_wr:   cpu_wr_q,
    wt:       wt_q,
    cnt_last: cnt_last,
    out_free: ~out_valid_q | ~out_stall_i
  };

endmodule

`default_nettype wire

@@ hw/rtl/tsac_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsac_ctrl
  import tsac_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic [1:0] in_action_i,
  output logic         in_stall_o,
  output cmd_t         cmd_o,
  input  wire status_t status_i
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'h0001,
    S_IDLE     = 15'h0002,
    S_DIV_GO   = 15'h0004,
    S_DIV      = 15'h0008,
    S_META_RD  = 15'h0010,
    S_LOOKUP   = 15'h0020,
    S_MISS     = 15'h0040,
    S_WB_RD    = 15'h0080,
    S_WB_OUT   = 15'h0100,
    S_REQ      = 15'h0200,
    S_FILL_WR  = 15'h0400,
    S_COMMIT   = 15'h0800,
    S_OUT_RD   = 15'h1000,
    S_OUT_WT   = 15'h2000,
    S_OUT_DONE = 15'h4000
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    cmd_o.dop  = D_NONE;
    cmd_o.esrc = E_RD;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ACT_FILL) begin
            if (pend_q) begin
              cmd_o.take_fill = 1'b1;
              state_d = S_FILL_WR;
            end
          end else if ((in_action_i == ACT_READ || in_action_i == ACT_WRITE) && !pend_q) begin
            cmd_o.take_cpu = 1'b1;
            state_d = S_DIV_GO;
          end
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_META_RD;
      end
      S_META_RD: begin
        cmd_o.meta_rd = 1'b1;
        state_d = pend_q ? S_COMMIT : S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d = status_i.hit ? S_COMMIT : S_MISS;
      end
      S_MISS: begin
        cmd_o.miss    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        pend_d = 1'b1;
        state_d = status_i.vdirty ? S_WB_RD : S_REQ;
      end
      S_WB_RD: begin
        cmd_o.dop = D_RD_WB;
        state_d = S_WB_OUT;
      end
      S_WB_OUT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.esrc = E_WB;
          if (status_i.cnt_last) begin
            cmd_o.cnt_clr = 1'b1;
            state_d = S_REQ;
          end else begin
            cmd_o.cnt_inc = 1'b1;
            state_d = S_WB_RD;
          end
        end
      end
      S_REQ: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.esrc = E_REQ;
          if (status_i.cnt_last) begin
            cmd_o.cnt_clr = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
      end
      S_FILL_WR: begin
        cmd_o.dop = D_WR_FILL;
        if (status_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_META_RD;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        pend_d = 1'b0;
        if (status_i.cpu_wr) begin
          cmd_o.dop = D_WR_CPU;
          state_d = status_i.wt ? S_OUT_WT : S_OUT_DONE;
        end else begin
          cmd_o.dop = D_RD_CPU;
          state_d = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.esrc = E_RD;
          state_d = S_IDLE;
        end
      end
      S_OUT_WT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.esrc = E_WT;
          state_d = S_OUT_DONE;
        end
      end
      S_OUT_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.esrc = E_DONE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/two_way_set_assoc_cache_controller.sv @@
// Two-way set-associative word cache, one LRU bit per set, write-allocate.
// Input channel (in_valid_i / in_stall_o, in_item_i): cpu read, cpu write or
// a fill word from memory. Output channel (out_valid_o / out_stall_i,
// out_item_o): read data, memory read requests, memory writes and write
// done items, the final item of an input marked by last.
// cfg_we_i / cfg_wdata_i set write-through mode (1) or write-back (0);
// write only while the block is idle.
// One input item is taken at a time. A cpu hit gives its first output item
// after the address is split by two constant reciprocal multiplications,
// a metadata read, a tag compare, a data access and the output register.
// The next item is taken once the last output item is emitted. After a
// setup state a miss emits one item per cycle while the receiver does not
// stall (each write-back item first needs a data store read). A fill word
// is written to the data store; the last one also commits the cpu access.
// After reset the metadata store is cleared one set per cycle, all SETS
// sets, with in_stall_o high. When the receiver stalls, the output register
// holds its item and the controller waits before producing the next one.
`timescale 1ns / 1ps
`default_nettype none

module two_way_set_assoc_cache_controller
  import tsac_pkg::*;
#(
  parameter int unsigned SETS  = SETS_DEF,
  parameter int unsigned WORDS = WORDS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_wdata_i,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_item_o
);

  cmd_t    cmd;
  status_t status;

  tsac_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_action_i(in_item_i.action),
    .in_stall_o,
    .cmd_o(cmd),
    .status_i(status)
  );

  tsac_dp #(.SETS(SETS), .WORDS(WORDS)) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_item_i,
    .out_stall_i,
    .out_valid_o,
    .out_item_o,
    .cmd_i(cmd),
    .status_o(status)
  );

endmodule

`default_nettype wire
